FILE: design/ils_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list store package
// Shared types, operation and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package ils_pkg;

   // Field widths of the request and response transfers.
   localparam int KIND_W  = 3;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 7;
   localparam int STAT_W  = 2;

   // Default number of list entries.
   localparam int DEF_CAPACITY = 64;

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_POP    = 3'd5;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] item_value;
   } ils_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic [LEN_W-1:0]          list_length;
      logic [STAT_W-1:0]         status;
   } ils_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;    // capture the accepted request
      logic stat_load;   // capture the status of the request
      logic ptr_load;    // load the pointer (position or tail)
      logic ptr_at_tail; // pointer load selects the last entry
      logic ptr_step;    // move the pointer one place
      logic rd_en;       // read the entry at the pointer
      logic wb_en;       // write that read data back one place over
      logic wr_val;      // write the request value
      logic wr_at_tail;  // value write goes to the end of the list
      logic cap_result;  // capture read data as the result value
      logic cnt_inc;     // grow the list by one
      logic cnt_dec;     // shrink the list by one
      logic rsp_load;    // load the response register
   } ils_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [STAT_W-1:0] status;
      logic              no_moves;   // insert position equals the length
      logic              shift_last; // pointer is at the final entry to move
      logic              rsp_busy;   // response register is held by the receiver
   } ils_sts_type;

endpackage

FILE: design/ils_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed list store controller
// Sequences each request through check, fetch, shift and response steps.
// ----------------------------------------------------------------------------
module ils_ctrl
   import ils_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ils_sts_type sts,
   output ils_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_FETCH  = 3'd2;
   localparam logic [2:0] S_CAPT   = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;
   localparam logic [2:0] S_DRAIN  = 3'd5;
   localparam logic [2:0] S_PUT    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.stat_load = 1'b1;
            if (sts.status != ST_OK) begin
               state_in = S_DONE;
            end else begin
               unique case (sts.kind) inside
                  KIND_APPEND: begin
                     cmd.wr_val     = 1'b1;
                     cmd.wr_at_tail = 1'b1;
                     cmd.cnt_inc    = 1'b1;
                     state_in       = S_DONE;
                  end
                  KIND_WRITE: begin
                     cmd.wr_val = 1'b1;
                     state_in   = S_DONE;
                  end
                  KIND_INSERT: begin
                     if (sts.no_moves) begin
                        cmd.wr_val  = 1'b1;
                        cmd.cnt_inc = 1'b1;
                        state_in    = S_DONE;
                     end else begin
                        cmd.ptr_load    = 1'b1;
                        cmd.ptr_at_tail = 1'b1;
                        state_in        = S_SHIFT;
                     end
                  end
                  KIND_POP: begin
                     cmd.ptr_load    = 1'b1;
                     cmd.ptr_at_tail = 1'b1;
                     state_in        = S_FETCH;
                  end
                  KIND_READ, KIND_REMOVE: begin
                     cmd.ptr_load = 1'b1;
                     state_in     = S_FETCH;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CAPT;
         end
         S_CAPT: begin
            cmd.cap_result = 1'b1;
            if (sts.kind == KIND_READ) begin
               state_in = S_DONE;
            end else if (sts.kind == KIND_POP || sts.shift_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.ptr_step = 1'b1;
               state_in     = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // One entry read per cycle, written back in the cycle after.
            cmd.rd_en = 1'b1;
            cmd.wb_en = 1'b1;
            if (sts.shift_last) begin
               state_in = S_DRAIN;
            end else begin
               cmd.ptr_step = 1'b1;
            end
         end
         S_DRAIN: begin
            // The final write-back uses the write port in this cycle.
            if (sts.kind == KIND_INSERT) begin
               state_in = S_PUT;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_PUT: begin
            cmd.wr_val  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/ils_datapath.sv
// ----------------------------------------------------------------------------
// Indexed list store datapath
// Entry memory, length counter, shift pointer, checks and response register.
// ----------------------------------------------------------------------------
module ils_datapath
   import ils_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic        clock,
   input  logic        reset,
   input  ils_req_type req_data,
   input  ils_cmd_type cmd,
   output ils_sts_type sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ils_rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

   logic [VALUE_W-1:0] store_ff [CAPACITY];
   ils_req_type        req_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [ADDR_W-1:0]  ptr_ff;
   logic [VALUE_W-1:0] rdata_ff;
   logic               wb_pend_ff;
   logic [ADDR_W-1:0]  wb_addr_ff;
   logic [VALUE_W-1:0] result_ff;
   logic [STAT_W-1:0]  stat_ff;
   logic               rsp_valid_ff;
   ils_rsp_type        rsp_ff;

   logic [CMP_W-1:0]  pos_x;
   logic [CMP_W-1:0]  cnt_x;
   logic [CMP_W-1:0]  tail_x;
   logic [CMP_W-1:0]  ptr_x;
   logic [ADDR_W-1:0] pos_a;
   logic [ADDR_W-1:0] tail_a;
   logic [ADDR_W-1:0] val_addr;
   logic [STAT_W-1:0] stat_now;
   logic              is_insert;

   assign pos_x     = CMP_W'(req_ff.position);
   assign cnt_x     = CMP_W'(count_ff);
   assign tail_x    = cnt_x - CMP_W'(1);
   assign ptr_x     = CMP_W'(ptr_ff);
   assign pos_a     = pos_x[ADDR_W-1:0];
   assign tail_a    = tail_x[ADDR_W-1:0];
   assign val_addr  = cmd.wr_at_tail ? cnt_x[ADDR_W-1:0] : pos_a;
   assign is_insert = (req_ff.kind == KIND_INSERT);

   // Range, full and empty checks for the held request.
   always_comb begin
      stat_now = ST_OK;
      unique case (req_ff.kind) inside
         KIND_APPEND: begin
            if (cnt_x >= CAP_X) stat_now = ST_FULL;
         end
         KIND_INSERT: begin
            if (pos_x > cnt_x) begin
               stat_now = ST_RANGE;
            end else if (cnt_x >= CAP_X) begin
               stat_now = ST_FULL;
            end
         end
         KIND_REMOVE, KIND_READ, KIND_WRITE: begin
            if (cnt_x == '0) begin
               stat_now = ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
               stat_now = ST_RANGE;
            end
         end
         KIND_POP: begin
            if (cnt_x == '0) stat_now = ST_EMPTY;
         end
         default: begin
            stat_now = ST_OK;
         end
      endcase
   end

   // Status toward the controller.
   always_comb begin
      sts.kind       = req_ff.kind;
      sts.status     = stat_now;
      sts.no_moves   = (pos_x == cnt_x);
      sts.shift_last = is_insert ? (ptr_x == pos_x) : (ptr_x == tail_x);
      sts.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   // Entry memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wb_pend_ff) begin
         store_ff[wb_addr_ff] <= rdata_ff;
      end else if (cmd.wr_val) begin
         store_ff[val_addr] <= req_ff.item_value;
      end
      if (cmd.rd_en) begin
         rdata_ff <= store_ff[ptr_ff];
      end
   end

   // Request, status, pointer, write-back address, result and response payload.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff    <= req_data;
         result_ff <= '0;
      end
      if (cmd.stat_load) begin
         stat_ff <= stat_now;
      end
      if (cmd.ptr_load) begin
         ptr_ff <= cmd.ptr_at_tail ? tail_a : pos_a;
      end else if (cmd.ptr_step) begin
         ptr_ff <= is_insert ? ptr_ff - ADDR_W'(1) : ptr_ff + ADDR_W'(1);
      end
      if (cmd.rd_en) begin
         wb_addr_ff <= is_insert ? ptr_ff + ADDR_W'(1) : ptr_ff - ADDR_W'(1);
      end
      if (cmd.cap_result) begin
         result_ff <= rdata_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff.result_value <= result_ff;
         rsp_ff.list_length  <= cnt_x[LEN_W-1:0];
         rsp_ff.status       <= stat_ff;
      end
   end

   // Control registers: length, pending write-back and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wb_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wb_pend_ff <= cmd.rd_en && cmd.wb_en;
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/indexed_list_store_unit.sv
// ----------------------------------------------------------------------------
// Indexed list store unit
// Bounded ordered list of signed 32-bit values addressed by position.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (kind, position, item_value) and each
// gives exactly one transfer on the rsp_ channel (result_value, list_length,
// status). A transfer takes place when valid is high and stall is low.
// The unit works on one request at a time and holds req_stall high from the
// cycle after a request is taken until its response is loaded.
// Steps from request transfer to response valid:
//   rejected request, append, write, unused kind: decide, done
//   read, pop: decide, fetch, capture, done
//   remove when entries move: decide, fetch, capture, one shift step per
//   moving entry, drain, done; else decide, fetch, capture, done
//   insert when entries move: decide, one shift step per moving entry,
//   drain, put, done; else decide, done
// The next request can be taken in the cycle after the response is loaded.
// The longest request is a remove at position 0 from a full list.
// Moves go one entry per cycle through the single write port of the entry
// memory.
// Reset empties the list at once; entry contents are not cleared.
// While the receiver stalls, the response is held; the next request can
// still be taken, but its response is loaded only after the held one is taken.
// ----------------------------------------------------------------------------
module indexed_list_store_unit
   import ils_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ils_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ils_rsp_type rsp_data
);

   ils_cmd_type cmd;
   ils_sts_type sts;

   // Sequencer.
   ils_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and response path.
   ils_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
